/* rtl/saa_pkg.sv */
// ============================================================================
// saa_pkg: shared types and constants for the sensor axis alignment block
// Coefficient layout, register indexes, orientation codes and reset values.
// ============================================================================
package saa_pkg;

    // Signed coefficient word and packed row of three
    localparam int COEF_WIDTH     = 16;
    localparam int COEF_ROW_WIDTH = 3 * COEF_WIDTH;

    // Configuration register index port width
    localparam int CFG_INDEX_WIDTH = 4;

    // Pipeline depth from request acceptance to result strobe
    localparam int LATENCY = 4;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MATRIX_ENABLE = 4'd0,
        REG_COEF_FOR_X    = 4'd1,
        REG_COEF_FOR_Y    = 4'd2,
        REG_COEF_FOR_Z    = 4'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ORIENT_CW0       = 3'd0,
        ORIENT_CW90      = 3'd1,
        ORIENT_CW180     = 3'd2,
        ORIENT_CW270     = 3'd3,
        ORIENT_CW0_FLIP  = 3'd4,
        ORIENT_CW90_FLIP = 3'd5,
        ORIENT_CW180_FLIP = 3'd6,
        ORIENT_CW270_FLIP = 3'd7
    } t_orient;

    // Identity matrix, 1.0 = 16384 in Q2.14
    localparam logic [COEF_ROW_WIDTH-1:0] COEF_X_RESET = 48'h0000_0000_4000;
    localparam logic [COEF_ROW_WIDTH-1:0] COEF_Y_RESET = 48'h0000_4000_0000;
    localparam logic [COEF_ROW_WIDTH-1:0] COEF_Z_RESET = 48'h4000_0000_0000;

endpackage

/* rtl/saa_dot.sv */
// ============================================================================
// saa_dot: one output axis of the rotation matrix
// Multiply, sum, round half to even and saturate over three register stages.
// ============================================================================
module saa_dot #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                  i_clk,
    input  logic [saa_pkg::COEF_ROW_WIDTH-1:0]    i_coefs,
    input  logic                                  i_matrix_enable,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_rx,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_ry,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_rz,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_bypass,
    output logic signed [SAMPLE_WIDTH-1:0]        o_out
);

    localparam int CW = saa_pkg::COEF_WIDTH;
    localparam int PW = SAMPLE_WIDTH + CW;           // product width
    localparam int SW = PW + 2;                      // sum of three products
    localparam int QR = SW - COEF_FRAC_BITS;         // floor quotient width
    // quotient plus round carry, never narrower than the clamp bounds need
    localparam int QW = (QR + 1 > SAMPLE_WIDTH) ? QR + 1 : SAMPLE_WIDTH + 1;

    localparam logic signed [QW-1:0] SAT_HI =
        QW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] SAT_LO = -SAT_HI - QW'(1);

    logic signed [CW-1:0] c0, c1, c2;

    assign c0 = i_coefs[0*CW +: CW];
    assign c1 = i_coefs[1*CW +: CW];
    assign c2 = i_coefs[2*CW +: CW];

    // Stage A: products
    logic signed [PW-1:0]           r_p0, r_p1, r_p2;
    logic signed [SAMPLE_WIDTH-1:0] r_byp_a;

    always_ff @(posedge i_clk) begin
        r_p0    <= PW'(c0) * PW'(i_rx);
        r_p1    <= PW'(c1) * PW'(i_ry);
        r_p2    <= PW'(c2) * PW'(i_rz);
        r_byp_a <= i_bypass;
    end

    // Stage B: exact sum
    logic signed [SW-1:0]           r_sum;
    logic signed [SAMPLE_WIDTH-1:0] r_byp_b;

    always_ff @(posedge i_clk) begin
        r_sum   <= SW'(r_p0) + SW'(r_p1) + SW'(r_p2);
        r_byp_b <= r_byp_a;
    end

    // Stage C: round to nearest, ties to even, then clamp
    logic signed [QR-1:0]           q;
    logic [COEF_FRAC_BITS-1:0]      rem;
    logic                           round_up;
    logic signed [QW-1:0]           q_rnd;
    logic signed [SAMPLE_WIDTH-1:0] n_out;

    always_comb begin
        q        = r_sum[SW-1:COEF_FRAC_BITS];
        rem      = r_sum[COEF_FRAC_BITS-1:0];
        round_up = rem[COEF_FRAC_BITS-1] & ((|rem[COEF_FRAC_BITS-2:0]) | q[0]);
        q_rnd    = QW'(q) + QW'({1'b0, round_up});
        if (!i_matrix_enable) begin
            n_out = r_byp_b;
        end else if (q_rnd > SAT_HI) begin
            n_out = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (q_rnd < SAT_LO) begin
            n_out = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            n_out = q_rnd[SAMPLE_WIDTH-1:0];
        end
    end

    logic signed [SAMPLE_WIDTH-1:0] r_out;

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out = r_out;

endmodule

/* rtl/sensor_axis_align.sv */
// ============================================================================
// sensor_axis_align: orientation remap and optional 3x3 rotation
// Top level: config registers, axis remap stage and three matrix channels.
// ============================================================================
// Takes one three-axis sample per clock. A request is accepted when i_start
// is high and o_busy is low; o_busy is only high during reset, so the block
// never pushes back. Every request yields exactly one result, shown for one
// cycle with o_valid high, in order. The result cannot be held off, so the
// receiver must take it on that cycle. Throughput is one request per clock;
// a request passes through four register stages: remap, multiply, three-way
// sum, round/saturate. The matrix path and the bypass path have the same
// register stages, so matrix_enable does not change timing. Config writes
// are always accepted outside reset and must only be issued while no
// request is in flight.
module sensor_axis_align #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    // Sample requests
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_in_x,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_in_y,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_in_z,
    input  logic [2:0]                             i_orientation,

    // Results
    output logic                                   o_valid,
    output logic signed [SAMPLE_WIDTH-1:0]         o_out_x,
    output logic signed [SAMPLE_WIDTH-1:0]         o_out_y,
    output logic signed [SAMPLE_WIDTH-1:0]         o_out_z,

    // Config writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [saa_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  logic [saa_pkg::COEF_ROW_WIDTH-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic                                r_matrix_enable;
    logic [saa_pkg::COEF_ROW_WIDTH-1:0]  r_coef_x, r_coef_y, r_coef_z;
    logic                                cfg_we;

    assign o_cfg_ready = i_rst_n;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_enable <= 1'b0;
            r_coef_x        <= saa_pkg::COEF_X_RESET;
            r_coef_y        <= saa_pkg::COEF_Y_RESET;
            r_coef_z        <= saa_pkg::COEF_Z_RESET;
        end else if (cfg_we) begin
            unique case (saa_pkg::t_cfg_reg'(i_cfg_index))
                saa_pkg::REG_MATRIX_ENABLE: r_matrix_enable <= i_cfg_data[0];
                saa_pkg::REG_COEF_FOR_X:    r_coef_x        <= i_cfg_data;
                saa_pkg::REG_COEF_FOR_Y:    r_coef_y        <= i_cfg_data;
                saa_pkg::REG_COEF_FOR_Z:    r_coef_z        <= i_cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request handshake and valid pipeline
    // ------------------------------------------------------------------
    logic                         accept;
    logic [saa_pkg::LATENCY-1:0]  r_vld;

    assign o_busy = ~i_rst_n;
    assign accept = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[saa_pkg::LATENCY-2:0], accept};
        end
    end

    assign o_valid = r_vld[saa_pkg::LATENCY-1];

    // ------------------------------------------------------------------
    // Stage 1: axis remap. Negation wraps, so the minimum maps to itself.
    // Flip variants negate z and also use their own x/y mapping.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] nx, ny, nz;
    logic signed [SAMPLE_WIDTH-1:0] n_rx, n_ry, n_rz;
    logic signed [SAMPLE_WIDTH-1:0] r_rx, r_ry, r_rz;

    assign nx = -i_in_x;
    assign ny = -i_in_y;
    assign nz = -i_in_z;

    always_comb begin
        unique case (saa_pkg::t_orient'(i_orientation))
            saa_pkg::ORIENT_CW0:        begin n_rx = i_in_x; n_ry = i_in_y; n_rz = i_in_z; end
            saa_pkg::ORIENT_CW90:       begin n_rx = i_in_y; n_ry = nx;     n_rz = i_in_z; end
            saa_pkg::ORIENT_CW180:      begin n_rx = nx;     n_ry = ny;     n_rz = i_in_z; end
            saa_pkg::ORIENT_CW270:      begin n_rx = ny;     n_ry = i_in_x; n_rz = i_in_z; end
            saa_pkg::ORIENT_CW0_FLIP:   begin n_rx = nx;     n_ry = i_in_y; n_rz = nz;     end
            saa_pkg::ORIENT_CW90_FLIP:  begin n_rx = i_in_y; n_ry = i_in_x; n_rz = nz;     end
            saa_pkg::ORIENT_CW180_FLIP: begin n_rx = i_in_x; n_ry = ny;     n_rz = nz;     end
            default:                    begin n_rx = ny;     n_ry = nx;     n_rz = nz;     end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rx <= n_rx;
        r_ry <= n_ry;
        r_rz <= n_rz;
    end

    // ------------------------------------------------------------------
    // Stages 2-4: one matrix row per output axis; the remapped axis rides
    // alongside as the bypass value when the matrix is off.
    // ------------------------------------------------------------------
    saa_dot #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dot_x (
        .i_clk           (i_clk),
        .i_coefs         (r_coef_x),
        .i_matrix_enable (r_matrix_enable),
        .i_rx            (r_rx),
        .i_ry            (r_ry),
        .i_rz            (r_rz),
        .i_bypass        (r_rx),
        .o_out           (o_out_x)
    );

    saa_dot #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dot_y (
        .i_clk           (i_clk),
        .i_coefs         (r_coef_y),
        .i_matrix_enable (r_matrix_enable),
        .i_rx            (r_rx),
        .i_ry            (r_ry),
        .i_rz            (r_rz),
        .i_bypass        (r_ry),
        .o_out           (o_out_y)
    );

    saa_dot #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dot_z (
        .i_clk           (i_clk),
        .i_coefs         (r_coef_z),
        .i_matrix_enable (r_matrix_enable),
        .i_rx            (r_rx),
        .i_ry            (r_ry),
        .i_rz            (r_rz),
        .i_bypass        (r_rz),
        .o_out           (o_out_z)
    );

endmodule

/* rtl/saa_check.sv */
// ============================================================================
// saa_check: port-level checks for sensor_axis_align
// Fixed latency, no invented results, no push-back outside reset.
// ============================================================================
module saa_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    // every accepted request yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##4 o_valid)
        else $error("accepted request produced no result after 4 cycles");

    // no result without a matching request
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 4))
        else $error("result strobe without a request 4 cycles earlier");

    // block never stalls requests outside reset
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised outside reset");

endmodule

bind sensor_axis_align saa_check u_saa_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);
